### rtl/core/afr_pkg.sv
// Package: types, constants and control/status structs for the addressed frame receiver.
`default_nettype none
package afr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 64;
    localparam int BYTE_W            = 8;
    localparam int IDX_W             = 6;

    localparam logic [7:0] PREAMBLE     = 8'hAB;
    localparam logic [7:0] DELIMITER    = 8'hFF;
    localparam logic [1:0] TYPE_DATA    = 2'b00;
    localparam logic [1:0] TYPE_COMMAND = 2'b01;
    localparam logic [5:0] CMD_SHOW     = 6'd1;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_DELIM,
        ST_ADDR,
        ST_OPCODE,
        ST_DATA,
        ST_FOREIGN,
        ST_SKIP,
        ST_SHOW_RD,
        ST_SHOW_LD
    } afr_state_t;

    // datapath -> controller
    typedef struct packed {
        logic byte_preamble;
        logic byte_delim;
        logic addr_match;
        logic op_data;
        logic op_show;
        logic count_zero;
        logic rem_one;
        logic show_last;
        logic out_free;
    } afr_status_t;

    // controller -> datapath
    typedef struct packed {
        logic load_count;
        logic load_skip;
        logic store_data;
        logic dec_skip;
        logic show_start;
        logic show_load;
        logic clear_valid;
    } afr_cmd_t;

endpackage
`default_nettype wire

### rtl/core/afr_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module afr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/core/afr_ctrl.sv
// Frame parse controller: state machine issuing datapath commands.
`default_nettype none
module afr_ctrl import afr_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire afr_status_t status,
    output afr_cmd_t         cmd
);
    afr_state_t state_reg;
    afr_state_t state_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg != ST_SHOW_RD) && (state_reg != ST_SHOW_LD);
        accept     = in_valid && in_ready;

        case (state_reg)
            ST_HUNT:
            begin
                if (accept)
                begin
                    state_next = status.byte_preamble ? ST_DELIM : ST_HUNT;
                end
            end
            ST_DELIM:
            begin
                if (accept)
                begin
                    state_next = status.byte_delim ? ST_ADDR : ST_HUNT;
                end
            end
            ST_ADDR:
            begin
                if (accept)
                begin
                    state_next = status.addr_match ? ST_OPCODE : ST_FOREIGN;
                end
            end
            ST_OPCODE:
            begin
                if (accept)
                begin
                    if (status.op_data)
                    begin
                        cmd.load_count = 1'b1;
                        state_next     = status.count_zero ? ST_OPCODE : ST_DATA;
                    end
                    else if (status.op_show)
                    begin
                        cmd.show_start = 1'b1;
                        state_next     = ST_SHOW_RD;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                if (accept)
                begin
                    cmd.store_data = 1'b1;
                    if (status.rem_one)
                    begin
                        state_next = ST_OPCODE;
                    end
                end
            end
            ST_FOREIGN:
            begin
                if (accept)
                begin
                    if (status.op_data && !status.count_zero)
                    begin
                        cmd.load_skip = 1'b1;
                        state_next    = ST_SKIP;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_SKIP:
            begin
                if (accept)
                begin
                    cmd.dec_skip = 1'b1;
                    if (status.rem_one)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_SHOW_RD:
            begin
                // read address settles, data appears next cycle
                state_next = ST_SHOW_LD;
            end
            ST_SHOW_LD:
            begin
                if (status.out_free)
                begin
                    cmd.show_load = 1'b1;
                    if (status.show_last)
                    begin
                        cmd.clear_valid = 1'b1;
                        state_next      = ST_HUNT;
                    end
                    else
                    begin
                        state_next = ST_SHOW_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/afr_datapath.sv
// Datapath: address register, counters, payload store with valid bits, output register.
`default_nettype none
module afr_datapath import afr_pkg::*; #(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [BYTE_W-1:0] cfg_wr_data,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic      [BYTE_W-1:0] frame_byte,
    output logic      [IDX_W-1:0]  byte_index,
    output logic                   last_byte,
    input  wire afr_cmd_t          cmd,
    output afr_status_t            status
);
    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic [BYTE_W-1:0]        dev_addr_reg;
    logic [IDX_W-1:0]         remaining_reg;
    logic [IDX_W-1:0]         pkt_len_reg;
    logic [AW-1:0]            show_idx_reg;
    logic [PAYLOAD_BYTES-1:0] valid_reg;
    logic                     out_valid_reg;
    logic [BYTE_W-1:0]        frame_byte_reg;
    logic [IDX_W-1:0]         byte_index_reg;
    logic                     last_byte_reg;

    logic [IDX_W-1:0]  wr_idx;
    logic              wr_in_range;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] show_data;

    assign wr_idx      = pkt_len_reg - remaining_reg;
    assign wr_in_range = {1'b0, wr_idx} < (IDX_W + 1)'(PAYLOAD_BYTES);
    assign ram_we      = cmd.store_data && wr_in_range;

    afr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx[AW-1:0]),
        .wdata (rx_byte),
        .raddr (show_idx_reg),
        .rdata (ram_rdata)
    );

    // never-written entries read as zero
    assign show_data = valid_reg[show_idx_reg] ? ram_rdata : '0;

    always_comb
    begin
        status.byte_preamble = (rx_byte == PREAMBLE);
        status.byte_delim    = (rx_byte == DELIMITER);
        status.addr_match    = (rx_byte == dev_addr_reg);
        status.op_data       = (rx_byte[7:6] == TYPE_DATA);
        status.op_show       = (rx_byte[7:6] == TYPE_COMMAND) && (rx_byte[5:0] == CMD_SHOW);
        status.count_zero    = (rx_byte[5:0] == '0);
        status.rem_one       = (remaining_reg == IDX_W'(1));
        status.show_last     = (show_idx_reg == AW'(PAYLOAD_BYTES - 1));
        status.out_free      = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= '0;
            remaining_reg <= '0;
            pkt_len_reg   <= '0;
            show_idx_reg  <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dev_addr_reg <= cfg_wr_data;
            end

            if (cmd.load_count)
            begin
                remaining_reg <= rx_byte[5:0];
                pkt_len_reg   <= rx_byte[5:0];
            end
            else if (cmd.load_skip)
            begin
                remaining_reg <= rx_byte[5:0];
            end
            else if (cmd.store_data)
            begin
                remaining_reg <= remaining_reg - IDX_W'(1);
                if (remaining_reg == IDX_W'(1))
                begin
                    pkt_len_reg <= '0;
                end
            end
            else if (cmd.dec_skip)
            begin
                remaining_reg <= remaining_reg - IDX_W'(1);
            end

            if (ram_we)
            begin
                valid_reg[wr_idx[AW-1:0]] <= 1'b1;
            end
            else if (cmd.clear_valid)
            begin
                valid_reg <= '0;
            end

            if (cmd.show_start)
            begin
                show_idx_reg <= '0;
            end
            else if (cmd.show_load && !status.show_last)
            begin
                show_idx_reg <= show_idx_reg + AW'(1);
            end

            if (cmd.show_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.show_load)
        begin
            frame_byte_reg <= show_data;
            byte_index_reg <= IDX_W'(show_idx_reg);
            last_byte_reg  <= status.show_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign byte_index = byte_index_reg;
    assign last_byte  = last_byte_reg;

endmodule
`default_nettype wire

### rtl/core/addressed_frame_receiver.sv
// Top level of the addressed frame receiver: controller plus datapath.
//
// Input channel (in_valid/in_ready/rx_byte): one received serial byte per word.
// The parser hunts for preamble 0xAB, delimiter 0xFF and an address byte that
// is compared with device_address (written through cfg_wr_en/cfg_wr_data).
// Data opcodes (type 00) store the following bytes from index 0; a show
// opcode (0x41) streams the whole payload store out and then clears it.
// Output channel (out_valid/out_ready): frame_byte, byte_index, last_byte;
// last_byte marks the final word of a show burst.
// Flow: non-show bytes are taken back to back. A show command holds in_ready
// low while it reads the store; each output word takes a store read, then a
// load of the output register once that register is free or out_ready is high.
// A stalled receiver (out_ready low) freezes the burst on the pending word;
// the last word may still wait while new input bytes are taken.
// Reset: parser back to preamble hunt, address 0, counters zero, all store
// entries read as zero (per-entry valid bits), output register empty.
`default_nettype none
module addressed_frame_receiver import afr_pkg::*; #(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [BYTE_W-1:0] cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [BYTE_W-1:0] frame_byte,
    output logic      [IDX_W-1:0]  byte_index,
    output logic                   last_byte
);
    afr_cmd_t    cmd;
    afr_status_t status;

    // parse state machine
    afr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, payload store and output register
    afr_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (rx_byte),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last_byte   (last_byte),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
`default_nettype wire

### verif/tb_addressed_frame_receiver.sv
// Testbench for the addressed frame receiver: random framed byte traffic checked against a predictor.
`timescale 1ns / 100ps
module tb_addressed_frame_receiver;
    import afr_pkg::*;

    // Timing knobs.
    localparam int  HALF_PERIOD   = 5;
    localparam int  RESET_CYCLES  = 5;
    localparam int  IDLE_PCT      = 32;
    localparam int  HOLD_CYCLES   = 400;   // long receiver hold-off, fills the block
    localparam int  SETTLE_CYCLES = 8;     // settle time before an address write
    localparam int  DRAIN_CYCLES  = 2 * PAYLOAD_BYTES_DEF + 20;
    localparam int  TIMEOUT_NS    = 5_000_000;
    localparam int  PHASE_WORDS   = 64;    // minimum random input words per address setting

    // Opcode shapes: the show command and the two type codes the parser rejects.
    localparam logic [7:0] SHOW_OP     = {TYPE_COMMAND, CMD_SHOW};
    localparam logic [1:0] TYPE_RSVD_A = 2'b10;
    localparam logic [1:0] TYPE_RSVD_B = 2'b11;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] index;
        logic       last;
    } burst_word_t;

    // Predicts the show bursts from the accepted byte stream and checks them in order.
    class frame_scoreboard;
        logic [7:0]    own_address;
        afr_state_t    parse_state;
        logic [5:0]    remaining;
        logic [5:0]    data_length;
        logic [7:0]    payload [PAYLOAD_BYTES_DEF];
        burst_word_t   expected_words [$];
        int            mismatches;
        int            words_checked;
        int            bursts;

        function new();
            own_address   = 8'h00;
            parse_state   = ST_HUNT;
            remaining     = '0;
            data_length   = '0;
            mismatches    = 0;
            words_checked = 0;
            bursts        = 0;
            foreach (payload[i]) payload[i] = 8'h00;
        endfunction

        function void set_address(logic [7:0] a);
            own_address = a;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        // One accepted rx byte advances the parser; a show opcode queues the whole store.
        function void note_byte(logic [7:0] b);
            burst_word_t w;
            logic [5:0]  slot;
            case (parse_state)
                ST_HUNT:  parse_state = (b == PREAMBLE) ? ST_DELIM : ST_HUNT;
                ST_DELIM: parse_state = (b == DELIMITER) ? ST_ADDR : ST_HUNT;
                ST_ADDR:  parse_state = (b == own_address) ? ST_OPCODE : ST_FOREIGN;
                ST_OPCODE: begin
                    if (b[7:6] == TYPE_DATA) begin
                        remaining   = b[5:0];
                        data_length = b[5:0];
                        parse_state = (b[5:0] != 0) ? ST_DATA : ST_OPCODE;
                    end
                    else if (b[7:6] == TYPE_COMMAND && b[5:0] == CMD_SHOW) begin
                        for (int i = 0; i < PAYLOAD_BYTES_DEF; i++) begin
                            w.data  = payload[i];
                            w.index = i[5:0];
                            w.last  = (i == PAYLOAD_BYTES_DEF - 1);
                            expected_words.push_back(w);
                            payload[i] = 8'h00;
                        end
                        bursts++;
                        parse_state = ST_HUNT;
                    end
                    else begin
                        parse_state = ST_HUNT;
                    end
                end
                ST_DATA: begin
                    slot = data_length - remaining;
                    if (slot < PAYLOAD_BYTES_DEF) payload[slot] = b;
                    remaining = remaining - 6'd1;
                    if (remaining == 0) begin
                        data_length = '0;
                        parse_state = ST_OPCODE;
                    end
                end
                ST_FOREIGN: begin
                    if (b[7:6] == TYPE_DATA) begin
                        remaining   = b[5:0];
                        parse_state = (b[5:0] != 0) ? ST_SKIP : ST_HUNT;
                    end
                    else begin
                        parse_state = ST_HUNT;
                    end
                end
                ST_SKIP: begin
                    remaining = remaining - 6'd1;
                    if (remaining == 0) parse_state = ST_HUNT;
                end
                default: parse_state = ST_HUNT;
            endcase
        endfunction

        task check_word(logic [7:0] data, logic [5:0] index, logic last);
            burst_word_t w;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%02h index=%0d last=%0b",
                                          data, index, last));
            end
            else begin
                w = expected_words.pop_front();
                words_checked++;
                if (data !== w.data)
                    report_mismatch($sformatf("frame_byte %02h, want %02h at index %0d",
                                              data, w.data, w.index));
                if (index !== w.index)
                    report_mismatch($sformatf("byte_index %0d, want %0d", index, w.index));
                if (last !== w.last)
                    report_mismatch($sformatf("last_byte %0b, want %0b at index %0d",
                                              last, w.last, w.index));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic       last_byte;

    frame_scoreboard sb = new();

    // Traffic shaping, written by the main sequence except hold_served.
    int         src_idle_pct = IDLE_PCT;
    bit         sink_no_idle = 1'b0;
    int         hold_requests = 0;
    int         hold_served = 0;     // owned by the receiver process
    logic [7:0] cur_address = 8'h00;
    int         words_sent = 0;
    int         settings_used = 0;

    addressed_frame_receiver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_byte  (frame_byte),
        .byte_index  (byte_index),
        .last_byte   (last_byte)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Receiver: random back-pressure, a stall-free stretch, and an occasional long hold-off.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (sink_no_idle)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every burst word taken at a rising edge goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(frame_byte, byte_index, last_byte);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #TIMEOUT_NS;
        $display("Timeout with %0d burst words outstanding", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

    // Offer one word; valid stays up until taken and is left up for the next call.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        words_sent++;
    endtask

    // Address writes only with nothing in flight: drop valid, drain the bursts, let the
    // parser settle.
    task automatic write_address(input logic [7:0] a);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = a;
        @(posedge clk);
        sb.set_address(a);
        cur_address = a;
        settings_used++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly short payloads, some empty, a few at the maximum count of 63.
    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 6'd63;
        else if (r < 12)
            return 6'd0;
        else
            return 6'($urandom_range(1, 10));
    endfunction

    // Opcodes that send the parser back to the hunt.
    function automatic logic [7:0] odd_opcode();
        logic [5:0] low;
        low = 6'($urandom_range(63));
        case ($urandom_range(2))
            0: return {TYPE_RSVD_A, low};
            1: return {TYPE_RSVD_B, low};
            default: return {TYPE_COMMAND, (low == CMD_SHOW) ? 6'd0 : low};
        endcase
    endfunction

    task automatic send_header(input logic [7:0] a);
        send_byte(PREAMBLE);
        send_byte(DELIMITER);
        send_byte(a);
    endtask

    task automatic send_own_frame(input bit force_show);
        int         n_ops;
        logic [5:0] cnt;
        send_header(cur_address);
        n_ops = $urandom_range(0, 3);
        repeat (n_ops)
        begin
            cnt = pick_count();
            send_byte({TYPE_DATA, cnt});
            repeat (cnt) send_byte(8'($urandom_range(255)));
        end
        if (force_show || $urandom_range(99) < 55)
            send_byte(SHOW_OP);
        else
            send_byte(odd_opcode());
    endtask

    // Frame for another station: data is skipped, a show does nothing.
    task automatic send_foreign_frame();
        logic [7:0] other;
        logic [5:0] cnt;
        do
            other = 8'($urandom_range(255));
        while (other == cur_address);
        send_header(other);
        case ($urandom_range(3))
            0: send_byte(SHOW_OP);
            1: send_byte(odd_opcode());
            default:
            begin
                cnt = pick_count();
                send_byte({TYPE_DATA, cnt});
                repeat (cnt) send_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    // Line noise and truncated headers.
    task automatic send_noise();
        case ($urandom_range(2))
            0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            1:
            begin
                send_byte(PREAMBLE);
                send_byte(8'($urandom_range(254)));   // anything but the delimiter
            end
            default:
            begin
                send_header(cur_address);
                send_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic run_setting(input logic [7:0] a, input bit no_idle, input bit with_hold);
        int start;
        int r;
        write_address(a);
        src_idle_pct = no_idle ? 0 : IDLE_PCT;
        sink_no_idle = no_idle;
        start = words_sent;
        if (with_hold)
        begin
            // Burst parks on the stalled output while the sender keeps pushing.
            hold_requests++;
            send_own_frame(1'b1);
        end
        while (words_sent - start < PHASE_WORDS)
        begin
            r = $urandom_range(99);
            if (r < 70)
                send_own_frame(1'b0);
            else if (r < 85)
                send_foreign_frame();
            else
                send_noise();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: address 0, empty data opcode, two data opcodes with the second
        // restarting at slot 0, show; foreign data skip, foreign show, foreign
        // empty count; rejected opcode on own address.
        write_address(8'h00);
        send_header(8'h00);
        send_byte({TYPE_DATA, 6'd0});
        send_byte({TYPE_DATA, 6'd2});
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte({TYPE_DATA, 6'd1});
        send_byte(8'h80);
        send_byte(SHOW_OP);
        send_header(8'h5A);
        send_byte({TYPE_DATA, 6'd3});
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_header(8'h5A);
        send_byte(SHOW_OP);
        send_header(8'h5A);
        send_byte({TYPE_DATA, 6'd0});
        send_header(8'h00);
        send_byte({TYPE_RSVD_B, 6'd0});

        // Random traffic under several addresses, extremes included.
        run_setting(8'h00, 1'b0, 1'b0);
        run_setting(8'hFF, 1'b1, 1'b0);     // no idling on either side
        run_setting(PREAMBLE, 1'b0, 1'b1);  // long receiver hold-off
        run_setting(8'($urandom_range(1, 254)), 1'b0, 1'b0);
        run_setting(8'h3C, 1'b0, 1'b0);

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d burst words never arrived", sb.pending()));

        $display("Sent %0d input words across %0d address settings",
                 words_sent, settings_used);
        $display("Checked %0d burst words from %0d show commands, %0d mismatches",
                 sb.words_checked, sb.bursts, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
